// ----- src/tensor_fibre_matrix_contraction_defines.svh -----
// assertion macros for the tensor fibre matrix contraction block
// needs clk and rst_n in the scope of every use
`ifndef TENSOR_FIBRE_MATRIX_CONTRACTION_DEFINES_SVH
`define TENSOR_FIBRE_MATRIX_CONTRACTION_DEFINES_SVH

// condition holds at every clock edge out of reset
`define TFMC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TFMC_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define TFMC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tfmc_pkg.sv -----
// shared constants, codes and types of the tensor fibre matrix contraction block
// no dependencies
`default_nettype none

package tfmc_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_DEF       = 3;
    localparam int FIBRE_N       = 3;
    localparam int ENTRY_IDX_W   = 2;

    // slave-side tdata layout
    localparam int ROW_LSB     = 0;
    localparam int COL_LSB     = ROW_LSB + ENTRY_IDX_W;
    localparam int VALUE_LSB   = COL_LSB + ENTRY_IDX_W;
    localparam int FIBRE_LSB   = VALUE_LSB + DATA_W;
    localparam int S_FIELDS_W  = FIBRE_LSB + FIBRE_N * DATA_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // master-side tdata layout
    localparam int M_TDATA_W   = FIBRE_N * DATA_W;

    // configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TRANSPOSE = '0;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_APPLY = 1'b1
    } tfmc_cmd_t;

    // pipeline load enables from the top level to every lane
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } tfmc_ctrl_t;

    // one lane's rounded and saturated result
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              clip;
    } tfmc_lane_res_t;

endpackage

`default_nettype wire

// ----- src/tensor_fibre_matrix_contraction.sv -----
// top level of the tensor fibre matrix contraction block: 3x3 matrix times fibre
// depends on tfmc_pkg, tfmc_lane and tfmc_merge
`default_nettype none

// Multiplies a loaded DIM x DIM Q16.16 coefficient matrix with one three-element
// tensor fibre per transfer. A load transfer (tuser = 0) writes the entry at
// entry_row/entry_col and gives no output; loads outside the matrix are dropped.
// An apply transfer (tuser = 1) gives one output transfer: M*f, or f*M when
// transpose_mode is set. Each sum is floored by FRAC_BITS and clamped to 32 bits;
// tuser on the output flags that some element was clamped. One transfer is taken
// every cycle while s_axis_tready is high; an apply result passes through the
// product register, sum register and output register in turn, one DIM-wide lane per
// result element working side by side. The input keeps flowing while a result
// waits on the output as long as a pipeline stage is free. A load takes effect
// for every apply transfer that follows it. transpose_mode sits at byte address 0
// and should be written only while no apply is in flight.

module tensor_fibre_matrix_contraction #(
    parameter int FRAC_BITS = tfmc_pkg::FRAC_BITS_DEF,
    parameter int DIM       = tfmc_pkg::DIM_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // input stream
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_row, entry_col, entry_value, fibre_a, fibre_b, fibre_c, zero pad
    input  wire  [tfmc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire                               s_axis_tuser,   // command
    // output stream
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [tfmc_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // out_a, out_b, out_c
    output logic                              m_axis_tuser,   // clipped
    // configuration
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [tfmc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [tfmc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tfmc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tfmc_pkg::*;

    logic                          in_xfer;
    logic                          apply_xfer;
    logic                          load_xfer;
    logic [ENTRY_IDX_W-1:0]        entry_row;
    logic [ENTRY_IDX_W-1:0]        entry_col;
    logic [DATA_W-1:0]             entry_value;

    // coefficient store, row major
    logic [DATA_W-1:0]             matrix_reg [DIM][DIM];
    logic                          transpose_reg;

    // pipeline occupancy
    logic                          prod_valid_reg;
    logic                          prod_valid_next;
    logic                          sum_valid_reg;
    logic                          sum_valid_next;
    logic                          prod_ready;
    logic                          sum_ready;
    logic                          merge_ready;
    tfmc_ctrl_t                    ctrl;

    logic [DIM-1:0][DATA_W-1:0]    fibre_vec;
    logic [DIM-1:0][DATA_W-1:0]    coeff_vec [DIM];
    tfmc_lane_res_t                lane_res [DIM];

    logic [REG_IDX_W-1:0]          reg_idx;
    logic                          cfg_write;

    // --- input decode
    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign apply_xfer  = in_xfer && (tfmc_cmd_t'(s_axis_tuser) == CMD_APPLY);
    assign load_xfer   = in_xfer && (tfmc_cmd_t'(s_axis_tuser) == CMD_LOAD);
    assign entry_row   = s_axis_tdata[ROW_LSB +: ENTRY_IDX_W];
    assign entry_col   = s_axis_tdata[COL_LSB +: ENTRY_IDX_W];
    assign entry_value = s_axis_tdata[VALUE_LSB +: DATA_W];

    // fibre elements beyond the three carried are zero
    generate
        for (genvar j = 0; j < DIM; j++)
        begin : g_fibre
            if (j < FIBRE_N)
            begin : g_carried
                assign fibre_vec[j] = s_axis_tdata[FIBRE_LSB + j*DATA_W +: DATA_W];
            end
            else
            begin : g_zero
                assign fibre_vec[j] = '0;
            end
        end
    endgenerate

    // --- coefficient store; a load lands before any later apply multiplies
    generate
        for (genvar r = 0; r < DIM; r++)
        begin : g_row
            for (genvar c = 0; c < DIM; c++)
            begin : g_col
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        matrix_reg[r][c] <= '0;
                    end
                    else if (load_xfer && entry_row == ENTRY_IDX_W'(r)
                             && entry_col == ENTRY_IDX_W'(c))
                    begin
                        matrix_reg[r][c] <= entry_value;
                    end
                end
            end
        end
    endgenerate

    // lane i takes row i, or column i in transpose mode
    always_comb
    begin
        for (int i = 0; i < DIM; i++)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                coeff_vec[i][j] = transpose_reg ? matrix_reg[j][i] : matrix_reg[i][j];
            end
        end
    end

    // --- pipeline control: a stage takes new data when empty or draining
    assign sum_ready     = !sum_valid_reg || merge_ready;
    assign prod_ready    = !prod_valid_reg || sum_ready;
    assign s_axis_tready = prod_ready;

    assign ctrl.prod_en  = apply_xfer;
    assign ctrl.sum_en   = prod_valid_reg && sum_ready;

    assign prod_valid_next = apply_xfer || (prod_valid_reg && !sum_ready);
    assign sum_valid_next  = ctrl.sum_en || (sum_valid_reg && !merge_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            sum_valid_reg  <= sum_valid_next;
        end
    end

    // --- one lane per result element
    generate
        for (genvar i = 0; i < DIM; i++)
        begin : g_lane
            tfmc_lane #(
                .DIM       (DIM),
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .clk   (clk),
                .ctrl  (ctrl),
                .coeff (coeff_vec[i]),
                .fibre (fibre_vec),
                .res   (lane_res[i])
            );
        end
    endgenerate

    tfmc_merge #(
        .DIM (DIM)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (sum_valid_reg),
        .in_ready      (merge_ready),
        .lane_res      (lane_res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // --- configuration port, word addressed
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transpose_reg <= 1'b0;
        end
        else if (cfg_write && reg_idx == REG_TRANSPOSE)
        begin
            transpose_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TRANSPOSE: prdata = APB_DATA_W'(transpose_reg);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/tfmc_lane.sv -----
// one lane: dot product of a coefficient vector with the fibre, then shift and saturate
// depends on tfmc_pkg
`default_nettype none

module tfmc_lane #(
    parameter int DIM       = tfmc_pkg::DIM_DEF,
    parameter int FRAC_BITS = tfmc_pkg::FRAC_BITS_DEF
) (
    input  wire                                       clk,
    input  wire  tfmc_pkg::tfmc_ctrl_t                ctrl,
    input  wire  [DIM-1:0][tfmc_pkg::DATA_W-1:0]      coeff,
    input  wire  [DIM-1:0][tfmc_pkg::DATA_W-1:0]      fibre,
    output tfmc_pkg::tfmc_lane_res_t                  res
);
    import tfmc_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + $clog2(DIM);

    logic signed [PROD_W-1:0] prod_reg [DIM];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  shifted;
    logic                     fits;

    // exact products
    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                prod_reg[j] <= $signed(coeff[j]) * $signed(fibre[j]);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < DIM; j++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    // floor shift, then clamp to 32 signed bits
    assign shifted = sum_reg >>> FRAC_BITS;
    assign fits    = (shifted[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){shifted[DATA_W-1]}});

    always_comb
    begin
        res.clip = !fits;
        if (fits)
        begin
            res.value = shifted[DATA_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            res.value = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            res.value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// ----- src/tfmc_merge.sv -----
// merging stage: gathers lane results and the clip flags into the output register
// depends on tfmc_pkg
`default_nettype none

module tfmc_merge #(
    parameter int DIM = tfmc_pkg::DIM_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  tfmc_pkg::tfmc_lane_res_t      lane_res [DIM],
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [tfmc_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // out_a, out_b, out_c
    output logic                                m_axis_tuser   // clipped
);
    import tfmc_pkg::*;

    logic                 tvalid_reg;
    logic                 tvalid_next;
    logic [M_TDATA_W-1:0] tdata_reg;
    logic                 tuser_reg;
    logic [DATA_W-1:0]    out_c_val;
    logic                 clip_any;
    logic                 load;

    generate
        if (DIM > 2)
        begin : g_out_c
            assign out_c_val = lane_res[2].value;
        end
        else
        begin : g_no_out_c
            assign out_c_val = '0;
        end
    endgenerate

    // every lane counts toward the flag, also one that is not reported
    always_comb
    begin
        clip_any = 1'b0;
        for (int i = 0; i < DIM; i++)
        begin
            clip_any = clip_any | lane_res[i].clip;
        end
    end

    assign in_ready    = !tvalid_reg || m_axis_tready;
    assign load        = in_valid && in_ready;
    assign tvalid_next = load || (tvalid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else
        begin
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= {out_c_val, lane_res[1].value, lane_res[0].value};
            tuser_reg <= clip_any;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

`default_nettype wire

// ----- src/tfmc_checker.sv -----
// port-level checks for the tensor fibre matrix contraction block, bound to the top level
// depends on tfmc_pkg and tensor_fibre_matrix_contraction_defines.svh
`default_nettype none

`include "tensor_fibre_matrix_contraction_defines.svh"

module tfmc_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_axis_tvalid,
    input wire                               s_axis_tready,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [tfmc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input wire                               m_axis_tuser,
    input wire                               psel,
    input wire                               penable,
    input wire                               pwrite,
    input wire [tfmc_pkg::APB_ADDR_W-1:0]    paddr,
    input wire [tfmc_pkg::APB_DATA_W-1:0]    pwdata,
    input wire [tfmc_pkg::APB_DATA_W-1:0]    prdata
);
    import tfmc_pkg::*;

    logic in_waiting;
    logic cfg_wr0;
    logic cfg_rd0;

    assign in_waiting = s_axis_tvalid;
    assign cfg_wr0    = psel && penable && pwrite && paddr[APB_ADDR_W-1:2] == REG_TRANSPOSE;
    assign cfg_rd0    = psel && !pwrite && paddr[APB_ADDR_W-1:2] == REG_TRANSPOSE;

    // a stalled result holds still
    `TFMC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")

    // a free output side never blocks the input
    `TFMC_ASSERT_IMPLY(a_in_ready, in_waiting && (!m_axis_tvalid || m_axis_tready), s_axis_tready, "input blocked with output free")

    // the mode register reads back what was written
    `TFMC_ASSERT_NEXT(a_cfg_readback, cfg_wr0, !cfg_rd0 || prdata[0] == $past(pwdata[0]), "transpose_mode readback mismatch")

    // unused register bits read as zero
    `TFMC_ASSERT_ALWAYS(a_cfg_upper_zero, prdata[APB_DATA_W-1:1] == '0, "nonzero reserved read bits")

endmodule

bind tensor_fibre_matrix_contraction tfmc_checker u_tfmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

`default_nettype wire
